@@ design/mbts_pkg.sv @@
// Shared constants, types and tanh breakpoint table for the multiband saturator.
`default_nettype none

package mbts_pkg;

  // Band structure
  localparam int NumBands     = 6;
  localparam int BandPorts    = 6;
  localparam int BandLimit    = (NumBands < BandPorts) ? NumBands : BandPorts;
  localparam int TanhSegments = 256;

  // Field widths
  localparam int SampleW = 24;
  localparam int GainW   = 16;
  localparam int TanhW   = 24;
  localparam int CfgIdxW = 4;

  // Soft clip lane
  localparam int BandGainW   = 2 * GainW;
  localparam int ArgW        = SampleW + BandGainW;
  localparam int ArgLimitBit = 49;           // |x| >= 4.0 in Q.47
  localparam int SegAw       = $clog2(TanhSegments);
  localparam int RomAw       = $clog2(TanhSegments + 1);
  localparam int PosW        = ArgLimitBit + SegAw;
  localparam int FracW       = 16;
  localparam int InterpW     = TanhW + FracW + 1;
  localparam int YW          = TanhW + 1;
  localparam int LaneStages  = 4;

  // Mix and output
  localparam int SumW      = YW + $clog2(BandLimit) + 1;
  localparam int WetMixW   = 2 * GainW;
  localparam int WetProdW  = SumW + WetMixW + 1;
  localparam int DryProdW  = SampleW + GainW + 1;
  localparam int DryShift  = 18;
  localparam int MixW      = ((WetProdW > DryProdW + DryShift) ?
                              WetProdW : (DryProdW + DryShift)) + 1;
  localparam int MixShift  = 30;
  localparam int Res1W     = MixW - MixShift + 1;
  localparam int OutProdW  = Res1W + GainW + 1;
  localparam int OutShift  = 12;
  localparam int MixStages = 5;
  localparam int Latency   = LaneStages + MixStages;

  localparam logic [MixW-1:0]     MixHalf = MixW'(1) << (MixShift - 1);
  localparam logic [OutProdW-1:0] OutHalf = OutProdW'(1) << (OutShift - 1);
  localparam int                  ClipMax = 8304721;

  // Register reset values and unity mix
  localparam logic [GainW-1:0] MixOne       = 16'd32768;
  localparam logic [GainW-1:0] DriveReset   = 16'd4096;
  localparam logic [GainW-1:0] WetCompReset = 16'd32768;
  localparam logic [GainW-1:0] MixReset     = 16'd32768;
  localparam logic [GainW-1:0] OutGainReset = 16'd4096;

  // Per-band tilt, Q1.15: 0.5, 0.75, 1.0, 1.0, 1.1, 1.2
  localparam logic [BandPorts-1:0][GainW-1:0] BandTilt = {
    16'd39322, 16'd36045, 16'd32768, 16'd32768, 16'd24576, 16'd16384
  };

  typedef enum logic [CfgIdxW-1:0] {
    CfgDriveGain  = 4'd0,
    CfgWetComp    = 4'd1,
    CfgMixAmount  = 4'd2,
    CfgOutputGain = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GainW-1:0]   drive_gain;
    logic [WetMixW-1:0] wet_mix;     // wet_compensation * clamped mix
    logic [GainW-1:0]   dry_mix;     // 1.0 - clamped mix
    logic [GainW-1:0]   post_gain;
  } cfg_t;

  typedef struct packed {
    logic               channel;
    logic [SampleW-1:0] dry;
  } lane_ctl_t;

  typedef logic [BandLimit-1:0][YW-1:0]           band_y_t;
  typedef logic [TanhSegments:0][TanhW-1:0]       tanh_rom_t;

  // Unsigned 64-bit restoring division, used only while building the table.
  function automatic logic [63:0] udiv64_f(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Breakpoints T_k = tanh(k * 4 / S) in Q1.23, built with integer steps:
  // r = e^(-8/S) in Q31 from a truncated series, q_k = r^k, T = (1-q)/(1+q).
  function automatic tanh_rom_t tanh_rom_f();
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] den;
    logic [63:0] num;
    tanh_rom_t   rom;
    a    = udiv64_f(64'd1 << 34, 64'(TanhSegments));
    term = 64'd1 << 31;
    e    = term;
    for (int n = 1; n <= 20; n++) begin
      term = udiv64_f((term * a) >> 31, 64'(n));
      e    = e + term;
    end
    r = udiv64_f((64'd1 << 62) + (e >> 1), e);
    q = 64'd1 << 31;
    for (int k = 0; k <= TanhSegments; k++) begin
      den    = (64'd1 << 31) + q;
      num    = ((64'd1 << 31) - q) << 23;
      rom[k] = TanhW'(udiv64_f(num + (den >> 1), den));
      q      = (q * r + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

  localparam tanh_rom_t TanhRom = tanh_rom_f();

endpackage

`default_nettype wire

@@ design/multiband_tanh_saturator_mix_unit.sv @@
// Top level: multiband tanh soft clip saturator with dry/wet mix and output clip.
// Pipeline: 4 soft clip lane stages, then 5 mix stages; the result strobe done_o
//   is driven by the valid bit that rides out of the last mix stage.
// Throughput: one beat per cycle; busy_o is always low, the pipeline never stalls.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst_ni, async low) empties the valid pipeline and loads register defaults.
`default_nettype none

module multiband_tanh_saturator_mix_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // item channel
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_0_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_1_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_2_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_3_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_4_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] band_sample_5_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] dry_sample_i,
  input  wire logic                                channel_i,
  // result channel
  output logic                                     done_o,
  output logic signed [mbts_pkg::SampleW-1:0]      out_sample_o,
  output logic                                     out_channel_o,
  // register write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [mbts_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [mbts_pkg::GainW-1:0]          cfg_data_i
);

  mbts_pkg::cfg_t                         cfg;
  logic signed [mbts_pkg::SampleW-1:0]    band_in [mbts_pkg::BandPorts];
  mbts_pkg::band_y_t                      band_y;
  logic                                   accept;
  logic [mbts_pkg::LaneStages-1:0]        ctl_valid_q;
  mbts_pkg::lane_ctl_t                    ctl_q [mbts_pkg::LaneStages];

  // Straight pipeline, nothing ever back-pressures the input.
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  assign band_in[0] = band_sample_0_i;
  assign band_in[1] = band_sample_1_i;
  assign band_in[2] = band_sample_2_i;
  assign band_in[3] = band_sample_3_i;
  assign band_in[4] = band_sample_4_i;
  assign band_in[5] = band_sample_5_i;

  mbts_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // One soft clip lane per band, each with its fixed tilt.
  for (genvar b = 0; b < mbts_pkg::BandLimit; b++) begin : g_lane
    logic signed [mbts_pkg::YW-1:0] lane_y;

    mbts_band_lane u_lane (
      .clk_i        (clk_i),
      .sample_i     (band_in[b]),
      .drive_gain_i (cfg.drive_gain),
      .tilt_i       (mbts_pkg::BandTilt[b]),
      .y_o          (lane_y)
    );

    assign band_y[b] = lane_y;
  end

  // Valid, channel tag and dry sample ride alongside the lanes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_valid_q <= '0;
    end else begin
      ctl_valid_q <= {ctl_valid_q[mbts_pkg::LaneStages-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0].channel <= channel_i;
    ctl_q[0].dry     <= dry_sample_i;
    for (int s = 1; s < mbts_pkg::LaneStages; s++) begin
      ctl_q[s] <= ctl_q[s-1];
    end
  end

  mbts_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (ctl_valid_q[mbts_pkg::LaneStages-1]),
    .ctl_i         (ctl_q[mbts_pkg::LaneStages-1]),
    .band_y_i      (band_y),
    .cfg_i         (cfg),
    .done_o        (done_o),
    .out_sample_o  (out_sample_o),
    .out_channel_o (out_channel_o)
  );

  // A result only appears a fixed latency after a start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, mbts_pkg::Latency))
    else $error("result strobe without matching start");

  // Channel tag stays aligned with its sample through both pipelines.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_channel_o == $past(channel_i, mbts_pkg::Latency)))
    else $error("channel tag misaligned with result");

  // Output stays inside the clip window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_sample_o <= mbts_pkg::ClipMax) &&
                (out_sample_o >= -mbts_pkg::ClipMax)))
    else $error("output sample outside clip range");

endmodule

`default_nettype wire

@@ design/mbts_cfg_regs.sv @@
// Configuration register file with derived mix gains.
`default_nettype none

module mbts_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [mbts_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mbts_pkg::GainW-1:0]   cfg_data_i,
  output logic                              cfg_ready_o,
  output mbts_pkg::cfg_t                    cfg_o
);

  logic [mbts_pkg::GainW-1:0]   drive_q, drive_d;
  logic [mbts_pkg::GainW-1:0]   wet_comp_q, wet_comp_d;
  logic [mbts_pkg::GainW-1:0]   mix_q, mix_d;
  logic [mbts_pkg::GainW-1:0]   out_gain_q, out_gain_d;
  logic [mbts_pkg::GainW-1:0]   mix_clamp;
  logic [mbts_pkg::WetMixW-1:0] wet_mix_q, wet_mix_d;
  logic [mbts_pkg::GainW-1:0]   dry_mix_q, dry_mix_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    drive_d    = drive_q;
    wet_comp_d = wet_comp_q;
    mix_d      = mix_q;
    out_gain_d = out_gain_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mbts_pkg::CfgDriveGain:  drive_d    = cfg_data_i;
        mbts_pkg::CfgWetComp:    wet_comp_d = cfg_data_i;
        mbts_pkg::CfgMixAmount:  mix_d      = cfg_data_i;
        mbts_pkg::CfgOutputGain: out_gain_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // mix above unity means all wet
  always_comb begin
    mix_clamp = (mix_d > mbts_pkg::MixOne) ? mbts_pkg::MixOne : mix_d;
    wet_mix_d = mbts_pkg::WetMixW'(wet_comp_d) * mbts_pkg::WetMixW'(mix_clamp);
    dry_mix_d = mbts_pkg::MixOne - mix_clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q    <= mbts_pkg::DriveReset;
      wet_comp_q <= mbts_pkg::WetCompReset;
      mix_q      <= mbts_pkg::MixReset;
      out_gain_q <= mbts_pkg::OutGainReset;
      wet_mix_q  <= mbts_pkg::WetMixW'(mbts_pkg::WetCompReset) *
                    mbts_pkg::WetMixW'(mbts_pkg::MixOne);
      dry_mix_q  <= '0;
    end else begin
      drive_q    <= drive_d;
      wet_comp_q <= wet_comp_d;
      mix_q      <= mix_d;
      out_gain_q <= out_gain_d;
      wet_mix_q  <= wet_mix_d;
      dry_mix_q  <= dry_mix_d;
    end
  end

  always_comb begin
    cfg_o.drive_gain = drive_q;
    cfg_o.wet_mix    = wet_mix_q;
    cfg_o.dry_mix    = dry_mix_q;
    cfg_o.post_gain  = out_gain_q;
  end

endmodule

`default_nettype wire

@@ design/mbts_band_lane.sv @@
// One band: drive scaling and piecewise-linear tanh soft clip, four stages.
`default_nettype none

module mbts_band_lane (
  input  wire logic                               clk_i,
  input  wire logic signed [mbts_pkg::SampleW-1:0] sample_i,
  input  wire logic [mbts_pkg::GainW-1:0]         drive_gain_i,
  input  wire logic [mbts_pkg::GainW-1:0]         tilt_i,
  output logic signed [mbts_pkg::YW-1:0]          y_o
);

  // stage 1: magnitude and band gain
  logic                               neg1_q;
  logic [mbts_pkg::SampleW-1:0]       mag1_q;
  logic [mbts_pkg::BandGainW-1:0]     gain1_q;
  // stage 2: tanh argument, Q.47
  logic                               neg2_q;
  logic [mbts_pkg::ArgW-1:0]          arg2_q;
  // stage 3: table lookup
  logic                               sat;
  logic [mbts_pkg::PosW-1:0]          pos;
  logic [mbts_pkg::SegAw-1:0]         seg;
  logic [mbts_pkg::RomAw-1:0]         lo_idx, hi_idx;
  logic [mbts_pkg::TanhW-1:0]         lo_val, hi_val;
  logic                               neg3_q;
  logic [mbts_pkg::TanhW-1:0]         lo3_q, delta3_q, delta3_d;
  logic [mbts_pkg::FracW-1:0]         frac3_q;
  // stage 4: interpolation
  logic [mbts_pkg::InterpW-1:0]       interp;
  logic [mbts_pkg::TanhW-1:0]         mag4;
  logic signed [mbts_pkg::YW-1:0]     y_q, y_d;

  always_ff @(posedge clk_i) begin
    neg1_q  <= sample_i[mbts_pkg::SampleW-1];
    mag1_q  <= sample_i[mbts_pkg::SampleW-1] ? (~sample_i + 1'b1) : sample_i;
    gain1_q <= mbts_pkg::BandGainW'(drive_gain_i) * mbts_pkg::BandGainW'(tilt_i);
  end

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    arg2_q <= mbts_pkg::ArgW'(mag1_q) * mbts_pkg::ArgW'(gain1_q);
  end

  always_comb begin
    sat    = |arg2_q[mbts_pkg::ArgW-1:mbts_pkg::ArgLimitBit];
    pos    = mbts_pkg::PosW'(arg2_q[mbts_pkg::ArgLimitBit-1:0]) *
             mbts_pkg::PosW'(mbts_pkg::TanhSegments);
    seg    = pos[mbts_pkg::PosW-1:mbts_pkg::ArgLimitBit];
    lo_idx = sat ? mbts_pkg::RomAw'(mbts_pkg::TanhSegments) : mbts_pkg::RomAw'(seg);
    hi_idx = mbts_pkg::RomAw'(seg) + 1'b1;
    lo_val = mbts_pkg::TanhRom[lo_idx];
    hi_val = mbts_pkg::TanhRom[hi_idx];
    delta3_d = (!sat && (hi_val > lo_val)) ? (hi_val - lo_val) : '0;
  end

  always_ff @(posedge clk_i) begin
    neg3_q   <= neg2_q;
    lo3_q    <= lo_val;
    delta3_q <= delta3_d;
    frac3_q  <= pos[mbts_pkg::ArgLimitBit-1 -: mbts_pkg::FracW];
  end

  always_comb begin
    interp = mbts_pkg::InterpW'(delta3_q) * mbts_pkg::InterpW'(frac3_q) +
             (mbts_pkg::InterpW'(1) << (mbts_pkg::FracW - 1));
    mag4   = lo3_q + mbts_pkg::TanhW'(interp >> mbts_pkg::FracW);
    y_d    = neg3_q ? -$signed(mbts_pkg::YW'(mag4)) : $signed(mbts_pkg::YW'(mag4));
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign y_o = y_q;

endmodule

`default_nettype wire

@@ design/mbts_mix.sv @@
// Band sum, wet/dry mix, output gain and hard clip, five stages.
`default_nettype none

module mbts_mix (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire mbts_pkg::lane_ctl_t                ctl_i,
  input  wire mbts_pkg::band_y_t                  band_y_i,
  input  wire mbts_pkg::cfg_t                     cfg_i,
  output logic                                    done_o,
  output logic signed [mbts_pkg::SampleW-1:0]     out_sample_o,
  output logic                                    out_channel_o
);

  logic [mbts_pkg::MixStages-1:0]           valid_q;
  logic [mbts_pkg::MixStages-1:0]           chan_q;

  logic signed [mbts_pkg::SumW-1:0]         sum_d, sum_q;
  logic signed [mbts_pkg::SampleW-1:0]      dry1_q;
  logic signed [mbts_pkg::WetProdW-1:0]     wetp_q;
  logic signed [mbts_pkg::DryProdW-1:0]     dryp_q;
  logic signed [mbts_pkg::MixW-1:0]         mixed;
  logic                                     mix_neg;
  logic [mbts_pkg::MixW-1:0]                mix_mag, mix_rnd;
  logic signed [mbts_pkg::Res1W-1:0]        res1_d, res1_q;
  logic signed [mbts_pkg::OutProdW-1:0]     oprod_q;
  logic                                     out_neg;
  logic [mbts_pkg::OutProdW-1:0]            out_mag, out_rnd;
  logic [mbts_pkg::SampleW-1:0]             clip_mag;
  logic signed [mbts_pkg::SampleW-1:0]      out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[mbts_pkg::MixStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q <= {chan_q[mbts_pkg::MixStages-2:0], ctl_i.channel};
  end

  // stage 1: band sum
  always_comb begin
    sum_d = '0;
    for (int b = 0; b < mbts_pkg::BandLimit; b++) begin
      sum_d = sum_d + mbts_pkg::SumW'($signed(band_y_i[b]));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    dry1_q <= $signed(ctl_i.dry);
  end

  // stage 2: wet and dry products
  always_ff @(posedge clk_i) begin
    wetp_q <= mbts_pkg::WetProdW'(sum_q) *
              mbts_pkg::WetProdW'($signed({1'b0, cfg_i.wet_mix}));
    dryp_q <= mbts_pkg::DryProdW'(dry1_q) *
              mbts_pkg::DryProdW'($signed({1'b0, cfg_i.dry_mix}));
  end

  // stage 3: mix, round half away from zero to Q.23
  always_comb begin
    mixed   = (mbts_pkg::MixW'(dryp_q) <<< mbts_pkg::DryShift) + mbts_pkg::MixW'(wetp_q);
    mix_neg = mixed[mbts_pkg::MixW-1];
    mix_mag = mix_neg ? -mixed : mixed;
    mix_rnd = (mix_mag + mbts_pkg::MixHalf) >> mbts_pkg::MixShift;
    res1_d  = mix_neg ? -$signed(mbts_pkg::Res1W'(mix_rnd))
                      : $signed(mbts_pkg::Res1W'(mix_rnd));
  end

  always_ff @(posedge clk_i) begin
    res1_q <= res1_d;
  end

  // stage 4: output gain
  always_ff @(posedge clk_i) begin
    oprod_q <= mbts_pkg::OutProdW'(res1_q) *
               mbts_pkg::OutProdW'($signed({1'b0, cfg_i.post_gain}));
  end

  // stage 5: round by 12 bits, symmetric clip
  always_comb begin
    out_neg  = oprod_q[mbts_pkg::OutProdW-1];
    out_mag  = out_neg ? -oprod_q : oprod_q;
    out_rnd  = (out_mag + mbts_pkg::OutHalf) >> mbts_pkg::OutShift;
    clip_mag = (out_rnd > mbts_pkg::OutProdW'(mbts_pkg::ClipMax)) ?
               mbts_pkg::SampleW'(mbts_pkg::ClipMax) : out_rnd[mbts_pkg::SampleW-1:0];
    out_d    = out_neg ? -$signed(clip_mag) : $signed(clip_mag);
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o        = valid_q[mbts_pkg::MixStages-1];
  assign out_sample_o  = out_q;
  assign out_channel_o = chan_q[mbts_pkg::MixStages-1];

endmodule

`default_nettype wire

@@ tb/tb_multiband_tanh_saturator_mix_unit.sv @@
// Self-checking testbench: directed table plus random frames against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_multiband_tanh_saturator_mix_unit;

  // Run shape
  localparam int ClkPeriod   = 4;
  localparam int ResetCycles = 12;
  localparam int DrainCycles = 16;      // pipeline is 9 deep, leave some slack
  localparam int CycleLimit  = 200000;  // hang guard, every correct run ends well before this limit
  localparam int PhaseCount  = 10;
  localparam int PhaseBeats  = 50;
  localparam int MaxGap      = 10;
  localparam int ReportLimit = 10;

  // Datapath constants of the saturator
  localparam int     BandCount = 6;
  localparam int     Segments  = 256;
  localparam longint SatLimit  = 8304721;  // 0.99 in Q1.23

  // Per-band tilt, Q1.15, sub band in the low slot
  localparam logic [BandCount-1:0][mbts_pkg::GainW-1:0] TiltQ15 = {
    16'd39322, 16'd36045, 16'd32768, 16'd32768, 16'd24576, 16'd16384
  };
  localparam logic [mbts_pkg::GainW-1:0]   MixUnity = 16'd32768;
  localparam logic [mbts_pkg::CfgIdxW-1:0] CfgSpare = 4'd9;    // past the register list

  typedef logic [mbts_pkg::SampleW-1:0] sample_t;

  localparam sample_t SMax     = 24'h7FFFFF;
  localparam sample_t SMin     = 24'h800000;
  localparam sample_t FourQ420 = 24'h400000;          // 4.0 in Q4.20
  localparam sample_t ClipPos  = sample_t'(SatLimit);
  localparam sample_t ClipNeg  = sample_t'(-SatLimit);

  typedef struct packed {
    logic [BandCount-1:0][mbts_pkg::SampleW-1:0] band;
    sample_t                                     dry;
    logic                                        channel;
  } frame_t;

  typedef struct packed {
    sample_t sample;
    logic    channel;
  } mix_out_t;

  typedef struct packed {
    logic [mbts_pkg::CfgIdxW-1:0] idx;
    logic [mbts_pkg::GainW-1:0]   data;
  } reg_write_t;

  typedef enum logic { RowFrame, RowWrite } row_kind_e;

  // One line of the directed table: either a register write or a frame,
  // optionally with its output sample pinned by hand.
  typedef struct packed {
    row_kind_e                    kind;
    logic [mbts_pkg::CfgIdxW-1:0] reg_idx;
    logic [mbts_pkg::GainW-1:0]   reg_data;
    frame_t                       frame;
    logic                         pinned;
    sample_t                      pinned_sample;
  } plan_row_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  // DUT drive side, all known from time zero
  logic                                        start     = 1'b0;
  logic [BandCount-1:0][mbts_pkg::SampleW-1:0] band_q    = '0;
  sample_t                                     dry_q     = '0;
  logic                                        channel_q = 1'b0;
  logic                                        cfg_valid = 1'b0;
  logic [mbts_pkg::CfgIdxW-1:0]                cfg_idx   = '0;
  logic [mbts_pkg::GainW-1:0]                  cfg_data  = '0;

  logic                                 busy;
  logic                                 done;
  logic signed [mbts_pkg::SampleW-1:0]  out_sample;
  logic                                 out_channel;
  logic                                 cfg_ready;

  multiband_tanh_saturator_mix_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_o          (busy),
    .band_sample_0_i (band_q[0]),
    .band_sample_1_i (band_q[1]),
    .band_sample_2_i (band_q[2]),
    .band_sample_3_i (band_q[3]),
    .band_sample_4_i (band_q[4]),
    .band_sample_5_i (band_q[5]),
    .dry_sample_i    (dry_q),
    .channel_i       (channel_q),
    .done_o          (done),
    .out_sample_o    (out_sample),
    .out_channel_o   (out_channel),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the register file and of the tanh breakpoints
  // ---------------------------------------------------------------------------
  logic [mbts_pkg::GainW-1:0] drive_gain_m  = 16'd4096;
  logic [mbts_pkg::GainW-1:0] wet_comp_m    = 16'd32768;
  logic [mbts_pkg::GainW-1:0] mix_amount_m  = 16'd32768;
  logic [mbts_pkg::GainW-1:0] out_gain_m    = 16'd4096;
  longint unsigned            tanh_pts [0:Segments];

  mix_out_t    mix_out_q [$];    // output samples still owed by the pipeline
  reg_write_t  reg_batch_q [$];  // register writes waiting for an idle window
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Breakpoints tanh(4k/S) in Q1.23 via r = e^(-8/S): tanh = (1 - r^k) / (1 + r^k).
  // Every step is integer and truncates exactly as the hardware table does.
  function automatic void build_tanh_points();
    longint unsigned step_a;
    longint unsigned term;
    longint unsigned exp_sum;
    longint unsigned ratio;
    longint unsigned pow_q;
    longint unsigned den;
    longint unsigned num;
    step_a  = (64'd1 << 34) / Segments;
    term    = 64'd1 << 31;
    exp_sum = term;
    for (int n = 1; n <= 20; n++) begin
      term    = ((term * step_a) >> 31) / n;
      exp_sum = exp_sum + term;
    end
    ratio = ((64'd1 << 62) + (exp_sum >> 1)) / exp_sum;
    pow_q = 64'd1 << 31;
    for (int k = 0; k <= Segments; k++) begin
      den         = (64'd1 << 31) + pow_q;
      num         = ((64'd1 << 31) - pow_q) << 23;
      tanh_pts[k] = (num + (den >> 1)) / den;
      pow_q       = (pow_q * ratio + (64'd1 << 30)) >> 31;
    end
  endfunction

  function automatic void track_reg_write(input logic [mbts_pkg::CfgIdxW-1:0] idx,
                                          input logic [mbts_pkg::GainW-1:0]   data);
    case (idx)
      mbts_pkg::CfgDriveGain:  drive_gain_m = data;
      mbts_pkg::CfgWetComp:    wet_comp_m   = data;
      mbts_pkg::CfgMixAmount:  mix_amount_m = data;
      mbts_pkg::CfgOutputGain: out_gain_m   = data;
      default: ;  // unknown index, dropped by the block
    endcase
  endfunction

  // Soft clip of one band: |x| * drive * tilt in Q.47, linear interpolation
  // between breakpoints, flat at tanh(4) from an argument of 4.0 upward.
  function automatic longint shaped_band(input sample_t x, input longint unsigned tilt);
    longint          sx;
    longint unsigned mag;
    longint unsigned arg;
    longint unsigned pos;
    longint unsigned seg;
    longint unsigned frac;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned y;
    sx  = longint'($signed(x));
    mag = (sx < 0) ? -sx : sx;
    arg = mag * drive_gain_m * tilt;
    if (arg >= (64'd4 << 47)) begin
      y = tanh_pts[Segments];
    end else begin
      pos  = arg * Segments;
      seg  = pos >> 49;
      frac = (pos >> 33) & 64'hFFFF;
      if (seg >= Segments) seg = Segments - 1;
      lo = tanh_pts[seg];
      hi = tanh_pts[seg + 1];
      y  = lo;
      if (hi > lo) y = y + (((hi - lo) * frac + 64'd32768) >> 16);
    end
    return (sx < 0) ? -longint'(y) : longint'(y);
  endfunction

  // Shift right with round half away from zero
  function automatic longint round_away(input longint v, input int sh);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic mix_out_t saturate_mix(input frame_t fr);
    longint   wet_sum;
    longint   wet;
    longint   dry;
    longint   wet_share;
    longint   mixed;
    longint   res;
    mix_out_t r;
    wet_sum = 0;
    for (int b = 0; b < BandCount; b++) wet_sum += shaped_band(fr.band[b], TiltQ15[b]);
    wet       = wet_sum * longint'(wet_comp_m);
    dry       = longint'($signed(fr.dry)) * 262144;          // Q4.20 -> Q.38
    wet_share = (mix_amount_m > MixUnity) ? longint'(MixUnity) : longint'(mix_amount_m);
    mixed     = dry * (32768 - wet_share) + wet * wet_share;  // Q.53
    res       = round_away(mixed, 30);
    res       = round_away(res * longint'(out_gain_m), 12);
    if (res > SatLimit) res = SatLimit;
    if (res < -SatLimit) res = -SatLimit;
    r.sample  = res[mbts_pkg::SampleW-1:0];
    r.channel = fr.channel;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: every done beat is matched against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
  endtask

  // Sampled right after the edge, so these are the values the edge took.
  always @(posedge clk) begin : check_beats
    mix_out_t want;
    if (rst_n && done) begin
      if (mix_out_q.size() == 0) begin
        flag_mismatch("beat with nothing pending, out_sample", 0, $signed(out_sample));
      end else begin
        want = mix_out_q.pop_front();
        if (out_sample !== want.sample)
          flag_mismatch("out_sample", $signed(want.sample), $signed(out_sample));
        if (out_channel !== want.channel)
          flag_mismatch("out_channel", want.channel, out_channel);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All called at a rising edge; each signal gets one NBA per edge.
  // ---------------------------------------------------------------------------

  // Present one frame after `gap` idle cycles, hold it until taken.
  // Start stays high at the accepting edge so back-to-back beats need no toggle.
  task automatic send_frame(input frame_t fr, input int gap, input logic pinned,
                            input sample_t pinned_sample);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    band_q    <= fr.band;
    dry_q     <= fr.dry;
    channel_q <= fr.channel;
    do @(posedge clk); while (busy);
    if (pinned) mix_out_q.push_back('{sample: pinned_sample, channel: fr.channel});
    else        mix_out_q.push_back(saturate_mix(fr));
  endtask

  // Stop sending and let the pipeline empty; every frame gives a beat, so an
  // empty prediction queue means nothing is in flight.
  task automatic wait_idle();
    start <= 1'b0;
    while (mix_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs();
    reg_write_t w;
    while (reg_batch_q.size() != 0) begin
      w = reg_batch_q.pop_front();
      cfg_valid <= 1'b1;
      cfg_idx   <= w.idx;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      track_reg_write(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic plan_row_t frame_row(
      input logic [BandCount-1:0][mbts_pkg::SampleW-1:0] bands,
      input sample_t dry, input logic ch,
      input logic pinned, input sample_t pinned_sample);
    plan_row_t r;
    r               = '0;
    r.kind          = RowFrame;
    r.frame.band    = bands;
    r.frame.dry     = dry;
    r.frame.channel = ch;
    r.pinned        = pinned;
    r.pinned_sample = pinned_sample;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [mbts_pkg::CfgIdxW-1:0] idx,
                                          input logic [mbts_pkg::GainW-1:0] data);
    plan_row_t r;
    r          = '0;
    r.kind     = RowWrite;
    r.reg_idx  = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Mix of rails, zero, full range, small signals (linear part of tanh with
  // low drive) and values around the 4.0 knee.
  function automatic sample_t draw_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return SMax;
      1: return SMin;
      2: return '0;
      3, 4: return sample_t'($urandom);
      5, 6: begin
        v = $urandom_range(0, 131071);
        return $urandom_range(0, 1) ? sample_t'(-v) : sample_t'(v);
      end
      default: begin
        v = 4194304 + $urandom_range(0, 64) - 32;
        return $urandom_range(0, 1) ? sample_t'(-v) : sample_t'(v);
      end
    endcase
  endfunction

  function automatic frame_t draw_frame();
    frame_t fr;
    for (int b = 0; b < BandCount; b++) fr.band[b] = draw_sample();
    fr.dry     = draw_sample();
    fr.channel = 1'($urandom_range(0, 1));
    return fr;
  endfunction

  // Register value: ends of the stated range, anything at all, or in range
  function automatic logic [mbts_pkg::GainW-1:0] pick_reg(
      input logic [mbts_pkg::GainW-1:0] lo,
      input logic [mbts_pkg::GainW-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1:    return lo;
      2, 3:    return hi;
      4:       return mbts_pkg::GainW'($urandom);
      default: return mbts_pkg::GainW'($urandom_range(lo, hi));
    endcase
  endfunction

  // 0: back to back, 1: uniform 0..MaxGap, 2: mostly dense with rare holes
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, MaxGap);
      default: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, MaxGap) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan [$];
    int        row;
    int        gap_mode;

    build_tanh_points();

    // Directed table. Pinned rows carry an output readable by eye; the rest
    // go through the predictor. Bands are listed top band first.
    // Reset defaults: drive 1.0, all wet, unity gains.
    plan.push_back(frame_row('0, '0, 1'b0, 1'b1, '0));                 // silence
    plan.push_back(frame_row({6{SMax}}, '0, 1'b1, 1'b1, ClipPos));      // all rails up
    plan.push_back(frame_row({6{SMin}}, SMax, 1'b0, 1'b1, ClipNeg));    // all rails down
    // Knee of the tanh table: band 2 has unity tilt, so 4.0 in is 4.0 at tanh
    plan.push_back(frame_row({24'd0, 24'd0, 24'd0, FourQ420, 24'd0, 24'd0}, '0, 1'b0, 1'b0, '0));
    plan.push_back(frame_row({24'd0, 24'd0, 24'd0, FourQ420 - 24'd1, 24'd0, 24'd0}, '0, 1'b1,
                             1'b0, '0));
    plan.push_back(frame_row({24'd0, 24'd0, 24'd0, 24'hC00000, 24'd0, 24'd0}, '0, 1'b0, 1'b0,
                             '0));
    plan.push_back(frame_row({24'h000400, 24'hFFF000, 24'h001234, 24'h000000, 24'h000000,
                              24'h200000}, 24'h012345, 1'b1, 1'b0, '0));
    plan.push_back(frame_row({24'h123456, 24'hEDCBA9, 24'h3FFFFF, 24'hC00001, 24'h0ABCDE,
                              24'hF54321}, SMax, 1'b1, 1'b0, '0));
    // Dry only: the dry sample is upshifted by 3 and clips at the rails
    plan.push_back(write_row(mbts_pkg::CfgMixAmount, 16'd0));
    plan.push_back(frame_row('0, SMax, 1'b0, 1'b1, ClipPos));
    plan.push_back(frame_row('0, SMin, 1'b1, 1'b1, ClipNeg));
    plan.push_back(frame_row({6{SMax}}, '0, 1'b0, 1'b1, '0));
    plan.push_back(frame_row('0, 24'h000100, 1'b1, 1'b0, '0));
    // Mix above unity clamps to all wet; zero drive zeroes the wet sum
    plan.push_back(write_row(mbts_pkg::CfgMixAmount, 16'hFFFF));
    plan.push_back(write_row(mbts_pkg::CfgDriveGain, 16'd0));
    plan.push_back(frame_row({6{SMax}}, SMax, 1'b1, 1'b1, '0));
    // Top drive, lowest wet compensation, half mix
    plan.push_back(write_row(mbts_pkg::CfgDriveGain, 16'd40960));
    plan.push_back(write_row(mbts_pkg::CfgWetComp, 16'd10362));
    plan.push_back(write_row(mbts_pkg::CfgMixAmount, 16'd16384));
    plan.push_back(frame_row({24'h000800, 24'hFFF800, 24'h010000, 24'hFF0000, 24'h000010,
                              24'hFFFFF0}, 24'hF00000, 1'b0, 1'b0, '0));
    plan.push_back(frame_row({24'hFFFF00, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0}, 24'h000800,
                             1'b1, 1'b0, '0));
    // Muted output
    plan.push_back(write_row(mbts_pkg::CfgOutputGain, 16'd0));
    plan.push_back(frame_row({6{SMax}}, SMax, 1'b0, 1'b1, '0));
    // Every register at its maximum code, beyond the stated range for all but the output gain
    plan.push_back(write_row(mbts_pkg::CfgOutputGain, 16'hFFFF));
    plan.push_back(write_row(mbts_pkg::CfgMixAmount, 16'hFFFF));
    plan.push_back(write_row(mbts_pkg::CfgDriveGain, 16'hFFFF));
    plan.push_back(write_row(mbts_pkg::CfgWetComp, 16'hFFFF));
    plan.push_back(frame_row({24'h000010, 24'hFFFFF0, 24'h000100, 24'hFFFF00, 24'h001000,
                              24'hFFF000}, 24'h000001, 1'b1, 1'b0, '0));
    plan.push_back(frame_row({6{SMin}}, SMin, 1'b0, 1'b0, '0));
    // Write to an index past the register file must change nothing
    plan.push_back(write_row(CfgSpare, 16'h1234));
    plan.push_back(frame_row({24'h000020, 24'h000400, 24'hFFC000, 24'h000003, 24'hFFFFFD,
                              24'h008000}, 24'hFF8000, 1'b1, 1'b0, '0));
    // Back to defaults
    plan.push_back(write_row(mbts_pkg::CfgDriveGain, 16'd4096));
    plan.push_back(write_row(mbts_pkg::CfgWetComp, 16'd32768));
    plan.push_back(write_row(mbts_pkg::CfgMixAmount, 16'd32768));
    plan.push_back(write_row(mbts_pkg::CfgOutputGain, 16'd4096));
    plan.push_back(frame_row({24'h080000, 24'hF80000, 24'h040000, 24'hFC0000, 24'h020000,
                              24'hFE0000}, 24'h100000, 1'b0, 1'b0, '0));

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; runs of writes go in as one batch once the pipe is empty
    row = 0;
    while (row < plan.size()) begin
      if (plan[row].kind == RowWrite) begin
        while (row < plan.size() && plan[row].kind == RowWrite) begin
          reg_batch_q.push_back('{idx: plan[row].reg_idx, data: plan[row].reg_data});
          row++;
        end
        wait_idle();
        program_regs();
      end else begin
        send_frame(plan[row].frame, $urandom_range(0, MaxGap), plan[row].pinned,
                   plan[row].pinned_sample);
        row++;
      end
    end

    // Random phases. Each phase drains the pipe (sender holds off until every
    // beat is back), reprograms all registers, then streams frames.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      reg_batch_q.push_back('{idx: mbts_pkg::CfgDriveGain,
                              data: pick_reg(16'd4096, 16'd40960)});
      reg_batch_q.push_back('{idx: mbts_pkg::CfgWetComp,
                              data: pick_reg(16'd10362, 16'd32768)});
      reg_batch_q.push_back('{idx: mbts_pkg::CfgMixAmount,
                              data: pick_reg(16'd0, 16'd32768)});
      reg_batch_q.push_back('{idx: mbts_pkg::CfgOutputGain,
                              data: pick_reg(16'd0, 16'hFFFF)});
      if ($urandom_range(0, 3) == 0)
        reg_batch_q.push_back('{idx: CfgSpare, data: mbts_pkg::GainW'($urandom)});
      wait_idle();
      program_regs();
      gap_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
      for (int i = 0; i < PhaseBeats; i++)
        send_frame(draw_frame(), draw_gap(gap_mode), 1'b0, '0);
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk);  // any stray beat shows up here
    if (mix_out_q.size() != 0) flag_mismatch("beats never delivered", mix_out_q.size(), 0);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
